@@ hw/rtl/rmq_pkg.sv @@
// -----------------------------------------------------------------------------
// rmq_pkg
// Field widths, stream packing and lane codes shared by the rotation matrix to
// quaternion block and its port checker.
// -----------------------------------------------------------------------------
package rmq_pkg;

   // One matrix element, signed fixed point.
   localparam int ELEM_W     = 16;
   localparam int NUM_ELEMS  = 9;

   // Result fields.
   localparam int QW_W       = 15;
   localparam int QXYZ_W     = 16;

   // Stream data widths, packed from the lowest bit up and padded to bytes.
   localparam int REQ_DATA_W = ((NUM_ELEMS * ELEM_W + 7) / 8) * 8;
   localparam int RSP_USED_W = QW_W + 3 * QXYZ_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // Element positions in the request data.
   localparam int EL_C0R0 = 0;
   localparam int EL_C1R1 = 1;
   localparam int EL_C2R2 = 2;
   localparam int EL_C2R1 = 3;
   localparam int EL_C1R2 = 4;
   localparam int EL_C0R2 = 5;
   localparam int EL_C2R0 = 6;
   localparam int EL_C1R0 = 7;
   localparam int EL_C0R1 = 8;

   // Square root lanes, one per quaternion component.
   localparam int NUM_LANES = 4;
   localparam int LANE_W    = 0;
   localparam int LANE_X    = 1;
   localparam int LANE_Y    = 2;
   localparam int LANE_Z    = 3;

   // Sign flags carried for the vector part.
   localparam int NUM_SIGNS = 3;
   localparam int SGN_X     = 0;
   localparam int SGN_Y     = 1;
   localparam int SGN_Z     = 2;

endpackage

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// -----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Pipelined conversion of a rotation matrix into a fixed-point quaternion.
// -----------------------------------------------------------------------------
// Usage:
//   A request on the req_ stream carries the nine rotation elements of a pose
//   matrix, each signed with FRAC_BITS fraction bits. For every request one
//   quaternion (w, x, y, z) leaves on the rsp_ stream in the same order.
//   Each component is half the truncated square root of one plus a signed sum
//   of the diagonal, clamped at zero and saturated to one; x, y and z take the
//   sign of an off-diagonal difference.
// Timing:
//   One stage forms the four sums, then one stage per root bit runs the four
//   restoring square roots in parallel, and an output register follows. The
//   root is RW bits wide (17 at FRAC_BITS = 14).
//   A new request is taken every cycle while the output drains.
// Reset and stall:
//   Reset empties every stage. When rsp_tready is low the valid stages close up
//   behind the held result; req_tready drops only once no stage is empty.
// -----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   // Fields from bit 0 up: c0r0, c1r1, c2r2, c2r1, c1r2, c0r2, c2r0, c1r0,
   // c0r1, 16 bits each.
   input  logic [rmq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: quat_w (15), quat_x (16), quat_y (16), quat_z (16),
   // one zero pad bit.
   output logic [rmq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import rmq_pkg::*;

   // Signed sum width, clamped radicand width, root width.
   localparam int SSW  = ((FRAC_BITS > ELEM_W + 1) ? FRAC_BITS : ELEM_W + 1) + 3;
   localparam int SUW  = SSW - 1;
   localparam int NW   = SUW + FRAC_BITS;
   localparam int RW   = (NW + 1) / 2;
   localparam int RADW = 2 * RW;
   localparam int MW   = (RW > QXYZ_W) ? RW : QXYZ_W;

   typedef struct packed {
      logic [RADW-1:0] rad;
      logic [RW-1:0]   root;
      logic [RW+1:0]   rem;
   } lane_type;

   typedef logic signed [SSW-1:0] sum_type;

   // One restoring square root step: bring down two radicand bits and try a
   // one in the next root position.
   function automatic lane_type root_step(input lane_type cur);
      lane_type        nxt;
      logic [RW+1:0]   part;
      logic [RW+1:0]   trial;
      part  = {cur.rem[RW-1:0], cur.rad[RADW-1 -: 2]};
      trial = {cur.root, 2'b01};
      nxt.rad = cur.rad << 2;
      if (part >= trial) begin
         nxt.rem  = part - trial;
         nxt.root = {cur.root[RW-2:0], 1'b1};
      end else begin
         nxt.rem  = part;
         nxt.root = {cur.root[RW-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Pipeline storage: stage 0 holds the sums, stage k holds k root bits.
   logic                     vld_ff  [0:RW];
   lane_type                 lane_ff [0:RW][0:NUM_LANES-1];
   logic [NUM_SIGNS-1:0]     sign_ff [0:RW];
   logic                     rdy     [0:RW];

   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_in;
   logic                     out_rdy;

   sum_type                  elem      [0:NUM_ELEMS-1];
   sum_type                  sum       [0:NUM_LANES-1];
   lane_type                 lane0_in  [0:NUM_LANES-1];
   logic [NUM_SIGNS-1:0]     sign0_in;

   localparam sum_type ONE_S = sum_type'(1) << FRAC_BITS;
   localparam logic [MW-1:0] ONE_M = MW'(1) << FRAC_BITS;

   // A stage takes new contents when it is empty or its contents move on.
   assign out_rdy    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = rdy[0];

   generate
      for (genvar k = 0; k <= RW; k++) begin : g_rdy
         if (k == RW) begin : g_last
            assign rdy[k] = !vld_ff[k] || out_rdy;
         end else begin : g_mid
            assign rdy[k] = !vld_ff[k] || rdy[k+1];
         end
      end
   endgenerate

   // Stage 0: the four diagonal sums and the three sign decisions.
   always_comb begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         elem[i] = SSW'($signed(req_tdata[ELEM_W*i +: ELEM_W]));
      end
      sum[LANE_W] = ONE_S + elem[EL_C0R0] + elem[EL_C1R1] + elem[EL_C2R2];
      sum[LANE_X] = ONE_S + elem[EL_C0R0] - elem[EL_C1R1] - elem[EL_C2R2];
      sum[LANE_Y] = ONE_S - elem[EL_C0R0] + elem[EL_C1R1] - elem[EL_C2R2];
      sum[LANE_Z] = ONE_S - elem[EL_C0R0] - elem[EL_C1R1] + elem[EL_C2R2];
      for (int l = 0; l < NUM_LANES; l++) begin
         lane0_in[l].root = '0;
         lane0_in[l].rem  = '0;
         if (sum[l][SSW-1]) begin
            lane0_in[l].rad = '0;
         end else begin
            lane0_in[l].rad = RADW'({sum[l][SUW-1:0], {FRAC_BITS{1'b0}}});
         end
      end
      sign0_in[SGN_X] = elem[EL_C2R1] < elem[EL_C1R2];
      sign0_in[SGN_Y] = elem[EL_C0R2] < elem[EL_C2R0];
      sign0_in[SGN_Z] = elem[EL_C1R0] < elem[EL_C0R1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= req_tvalid;
      end
      if (rdy[0]) begin
         lane_ff[0] <= lane0_in;
         sign_ff[0] <= sign0_in;
      end
   end

   // Root stages, one result bit per stage in each lane.
   generate
      for (genvar k = 1; k <= RW; k++) begin : g_root
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
            if (rdy[k]) begin
               for (int l = 0; l < NUM_LANES; l++) begin
                  lane_ff[k][l] <= root_step(lane_ff[k-1][l]);
               end
               sign_ff[k] <= sign_ff[k-1];
            end
         end
      end
   endgenerate

   // Output: halve, saturate to one, apply sign and pack.
   always_comb begin
      logic [MW-1:0]     mag [0:NUM_LANES-1];
      logic [QXYZ_W-1:0] vec [1:NUM_LANES-1];
      for (int l = 0; l < NUM_LANES; l++) begin
         mag[l] = MW'(lane_ff[RW][l].root >> 1);
         if (mag[l] > ONE_M) begin
            mag[l] = ONE_M;
         end
      end
      for (int l = 1; l < NUM_LANES; l++) begin
         if (sign_ff[RW][l-1]) begin
            vec[l] = QXYZ_W'(-mag[l][QXYZ_W-1:0]);
         end else begin
            vec[l] = mag[l][QXYZ_W-1:0];
         end
      end
      rsp_tdata_in = RSP_DATA_W'({vec[LANE_Z], vec[LANE_Y], vec[LANE_X],
                                  mag[LANE_W][QW_W-1:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_tvalid_ff <= vld_ff[RW];
      end
      if (out_rdy) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ hw/rtl/rmq_checker.sv @@
// -----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// -----------------------------------------------------------------------------
module rmq_checker #(
   parameter int FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tready,
   input  logic [rmq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import rmq_pkg::*;

   localparam int W_LIMIT = 1 << FRAC_BITS;

   // True when a signed vector component lies between minus one and one.
   function automatic bit in_unit_range(input logic [QXYZ_W-1:0] v);
      return (int'($signed(v)) >= -W_LIMIT) && (int'($signed(v)) <= W_LIMIT);
   endfunction

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset empties the pipeline, so nothing is offered right after it.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // The scalar part is saturated at one whenever it fits its field.
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (FRAC_BITS > QW_W - 1) ||
                     (int'(rsp_tdata[QW_W-1:0]) <= W_LIMIT))
      else $error("quat_w above one");

   // The vector part stays between minus one and one whenever it fits its field.
   a_vec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (FRAC_BITS > QXYZ_W - 2) ||
                     (in_unit_range(rsp_tdata[QW_W +: QXYZ_W]) &&
                      in_unit_range(rsp_tdata[QW_W + QXYZ_W +: QXYZ_W]) &&
                      in_unit_range(rsp_tdata[QW_W + 2*QXYZ_W +: QXYZ_W])))
      else $error("vector component outside one");

   // A ready receiver lets every stage move, so the request side never stalls.
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while the receiver is ready");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
